@@ src/lbs_pkg.sv @@
// Shared types, constants and the saturation helper for the skinning block.
// No dependencies.
`default_nettype none
package lbs_pkg;

	localparam int WORDS_PER_BONE = 12;
	localparam int MAX_SLOTS = 4;
	localparam int SLOT_BITS = 8;
	localparam int WEIGHT_BITS = 16;
	localparam int UNUSED_BIT = 7;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SKIN = 1'b1;

	typedef logic signed [31:0] word_t;
	typedef logic signed [15:0] nrm_t;
	typedef logic signed [49:0] nsum_t;
	typedef logic signed [66:0] wide_t;

	typedef struct packed {
		logic clip;
		word_t val;
	} sat_t;

	typedef struct packed {
		logic zero;
		nrm_t nx;
		nrm_t ny;
		nrm_t nz;
	} norm_res_t;

	localparam wide_t SAT_MAX = 67'sh0_7FFF_FFFF;
	localparam wide_t SAT_MIN = -67'sh0_8000_0000;

	function automatic sat_t sat32(input wide_t v);
		sat_t r;
		if (v > SAT_MAX) begin
			r.clip = 1'b1;
			r.val = 32'sh7FFF_FFFF;
		end else if (v < SAT_MIN) begin
			r.clip = 1'b1;
			r.val = 32'sh8000_0000;
		end else begin
			r.clip = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/lbs_in_if.sv @@
// Input channel of the skinning block: valid/ready plus one load or vertex item.
// Depends on nothing.
`default_nettype none
interface lbs_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [6:0] bone_index;
	logic [3:0] matrix_element;
	logic signed [31:0] matrix_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] nrm_x;
	logic signed [15:0] nrm_y;
	logic signed [15:0] nrm_z;
	logic [31:0] bone_slots;
	logic [63:0] slot_weights;

	modport source (output valid, operation, bone_index, matrix_element, matrix_value,
		pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, bone_slots, slot_weights, input ready);
	modport sink (input valid, operation, bone_index, matrix_element, matrix_value,
		pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, bone_slots, slot_weights, output ready);
endinterface
`default_nettype wire

@@ src/lbs_out_if.sv @@
// Output channel of the skinning block: valid/ready plus one skinned vertex.
// Depends on nothing.
`default_nettype none
interface lbs_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [15:0] out_nx;
	logic signed [15:0] out_ny;
	logic signed [15:0] out_nz;
	logic normal_zero;
	logic saturated;

	modport source (output valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
		normal_zero, saturated, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
		normal_zero, saturated, output ready);
endinterface
`default_nettype wire

@@ src/lbs_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1536
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ src/lbs_norm.sv @@
// Normal scaling unit: range shift, sum of squares, bit-serial square root and
// restoring division per component. Depends on lbs_pkg.
`default_nettype none
module lbs_norm import lbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  nsum_t [2:0] nsum,
	output logic done,
	output norm_res_t res
);
	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SHIFT = 3'd1;
	localparam logic [2:0] N_SQ    = 3'd2;
	localparam logic [2:0] N_SQRT  = 3'd3;
	localparam logic [2:0] N_DIV   = 3'd4;

	logic [2:0] state_q;
	logic [49:0] mag_q [3];
	logic [2:0] neg_q;
	logic [1:0] k_q;
	logic [61:0] len2_q;
	logic [63:0] x_q, res_q, bit_q;
	logic [4:0] dstep_q;
	logic [31:0] rem_q;
	logic [15:0] low_q, quo_q;
	nrm_t nout_q [3];
	logic zero_q;

	logic big, tiny;
	logic zin;
	logic [30:0] root;
	logic [29:0] m30;
	logic [59:0] sq;
	logic [63:0] trial;
	logic [44:0] num;
	logic [31:0] dtrial;
	logic [15:0] qclamp;

	always_comb begin
		big = 1'b0;
		tiny = 1'b1;
		for (int r = 0; r < 3; r++) begin
			big = big | (|mag_q[r][49:30]);
			tiny = tiny & ~(|mag_q[r][49:29]);
		end
		zin = (nsum[0] == '0 && nsum[1] == '0 && nsum[2] == '0);
		root = res_q[30:0];
		m30 = mag_q[k_q][29:0];
		sq = {30'b0, m30} * {30'b0, m30};
		trial = res_q + bit_q;
		num = {1'b0, m30, 14'b0} + {15'b0, root[30:1]};
		dtrial = {rem_q[30:0], low_q[15]};
		qclamp = quo_q[15] ? 16'h7FFF : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done <= 1'b0;
		end else begin
			done <= ((state_q == N_IDLE) && start && zin)
				|| ((state_q == N_DIV) && (dstep_q == 5'd17) && (k_q == 2'd2));
			case (state_q)
				N_IDLE: begin
					if (start && !zin) begin
						state_q <= N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (!big && !tiny) begin
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					if (k_q == 2'd2) begin
						state_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					if (bit_q[0]) begin
						state_q <= N_DIV;
					end
				end
				N_DIV: begin
					if (dstep_q == 5'd17 && k_q == 2'd2) begin
						state_q <= N_IDLE;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int r = 0; r < 3; r++) begin
						neg_q[r] <= nsum[r][49];
						mag_q[r] <= nsum[r][49] ? 50'(-nsum[r]) : 50'(nsum[r]);
						nout_q[r] <= '0;
					end
					zero_q <= zin;
					k_q <= '0;
					len2_q <= '0;
				end
			end
			N_SHIFT: begin
				for (int r = 0; r < 3; r++) begin
					if (big) begin
						mag_q[r] <= mag_q[r] >> 1;
					end else if (tiny) begin
						mag_q[r] <= mag_q[r] << 1;
					end
				end
			end
			N_SQ: begin
				len2_q <= len2_q + 62'(sq);
				if (k_q == 2'd2) begin
					k_q <= '0;
					x_q <= {2'b0, len2_q + 62'(sq)};
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			N_SQRT: begin
				if (x_q >= trial) begin
					x_q <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				dstep_q <= '0;
			end
			N_DIV: begin
				if (dstep_q == 5'd0) begin
					rem_q <= {3'b0, num[44:16]};
					low_q <= num[15:0];
					quo_q <= '0;
					dstep_q <= dstep_q + 5'd1;
				end else if (dstep_q == 5'd17) begin
					nout_q[k_q] <= neg_q[k_q] ? -nrm_t'(qclamp) : nrm_t'(qclamp);
					dstep_q <= '0;
					k_q <= k_q + 2'd1;
				end else begin
					if (dtrial >= {1'b0, root}) begin
						rem_q <= dtrial - {1'b0, root};
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						rem_q <= dtrial;
						quo_q <= {quo_q[14:0], 1'b0};
					end
					low_q <= low_q << 1;
					dstep_q <= dstep_q + 5'd1;
				end
			end
			default: ;
		endcase
	end

	assign res = '{zero: zero_q, nx: nout_q[0], ny: nout_q[1], nz: nout_q[2]};
endmodule
`default_nettype wire

@@ src/linear_blend_vertex_skinning.sv @@
// Linear blend skinning with up to four bones per vertex.
// Depends on lbs_pkg, lbs_in_if, lbs_out_if, lbs_ram and lbs_norm.
//
// Channels: req takes load items (operation 0), each writing one Q16.16 word
// of the bone matrix table, and vertex items (operation 1). rsp gives one
// skinned vertex per vertex item; load items give nothing.
// A load item is done at its transfer.
// A vertex item is worked on alone: one table read per used slot and matrix
// word (up to 48 reads, one memory port), a blend step, twelve multiply steps
// for position and normal, then the normal unit (idle when the normal comes out
// zero): up to 29 range shifts, three squares, 32 square-root steps and 54
// division steps. req is ready again once the result has moved to the output
// register.
// Reset clears the state machines and valid flags; the table contents stay undefined until
// written. When rsp stalls, the finished vertex holds in the output register
// and the block still takes load items and the next vertex; a second result
// waits inside until the first one is taken.
`default_nettype none
module linear_blend_vertex_skinning import lbs_pkg::*; #(
	parameter int BONE_COUNT = 128,
	parameter int SLOTS_PER_VERTEX = 4
) (
	input logic clk,
	input logic arst_n,
	lbs_in_if.sink req,
	lbs_out_if.source rsp
);
	localparam int DEPTH = BONE_COUNT * WORDS_PER_BONE;
	localparam int AW = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_BLEND = 3'd2;
	localparam logic [2:0] ST_XFORM = 3'd3;
	localparam logic [2:0] ST_NORM  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [31:0] slots_q;
	logic [63:0] wts_q;
	word_t p_q [3];
	nrm_t n_q [3];
	logic [2:0] slot_q;
	logic [3:0] elem_q;

	logic rd_v_s1, v_s2;
	logic [3:0] elem_s1, elem_s2;
	logic [15:0] w_s1;
	logic signed [48:0] prod_s2;
	logic signed [50:0] acc_q [WORDS_PER_BONE];
	word_t m_q [WORDS_PER_BONE];
	logic sat_q;

	logic [1:0] r_q, c_q;
	logic x_end_q;
	logic xv_s1;
	logic [1:0] r_s1, c_s1;
	logic signed [63:0] pp_s1;
	logic signed [47:0] np_s1;
	logic signed [65:0] psum_q;
	nsum_t nsum_q;
	word_t o_q [3];
	nsum_t [2:0] nres_q;
	logic nstart_q;

	logic ov_q;

	logic [7:0] cur_bone;
	logic [15:0] cur_w;
	logic slot_ok, issue, ld_ok, ld_we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] rdata;
	word_t p_op;
	nrm_t n_op;
	logic signed [65:0] newp;
	nsum_t newn;
	sat_t osat;
	sat_t msat [WORDS_PER_BONE];
	logic signed [51:0] mrnd [WORDS_PER_BONE];
	logic mclip;
	logic ndone;
	norm_res_t nres;
	logic in_xfer, out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign in_xfer = req.valid && req.ready;
	assign out_free = !ov_q || rsp.ready;

	always_comb begin
		cur_bone = slots_q[SLOT_BITS*slot_q[1:0] +: SLOT_BITS];
		cur_w = wts_q[WEIGHT_BITS*slot_q[1:0] +: WEIGHT_BITS];
		slot_ok = !cur_bone[UNUSED_BIT] && (32'(cur_bone) < BONE_COUNT)
			&& (32'(slot_q) < SLOTS_PER_VERTEX);
		issue = (state_q == ST_READ) && !slot_q[2] && slot_ok;
		raddr = AW'(32'(cur_bone) * WORDS_PER_BONE + 32'(elem_q));
		ld_ok = (32'(req.bone_index) < BONE_COUNT)
			&& (32'(req.matrix_element) < WORDS_PER_BONE);
		ld_we = in_xfer && (req.operation == OP_LOAD) && ld_ok;
		waddr = AW'(32'(req.bone_index) * WORDS_PER_BONE + 32'(req.matrix_element));
		case (c_q)
			2'd0: begin p_op = p_q[0]; n_op = n_q[0]; end
			2'd1: begin p_op = p_q[1]; n_op = n_q[1]; end
			2'd2: begin p_op = p_q[2]; n_op = n_q[2]; end
			default: begin p_op = 32'sh0001_0000; n_op = '0; end
		endcase
		newp = (c_s1 == 2'd0 ? 66'sd0 : psum_q) + 66'(pp_s1);
		newn = (c_s1 == 2'd0 ? 50'sd0 : nsum_q) + 50'(np_s1);
		osat = sat32((67'(newp) + 67'sd32768) >>> 16);
		mclip = 1'b0;
		for (int e = 0; e < WORDS_PER_BONE; e++) begin
			mrnd[e] = (52'(acc_q[e]) + 52'sd16384) >>> 15;
			msat[e] = sat32(67'(mrnd[e]));
			mclip = mclip | msat[e].clip;
		end
	end

	lbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
		.clk(clk),
		.we(ld_we),
		.waddr(waddr),
		.wdata(req.matrix_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	lbs_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.start(nstart_q),
		.nsum(nres_q),
		.done(ndone),
		.res(nres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			xv_s1 <= 1'b0;
			nstart_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			v_s2 <= rd_v_s1;
			xv_s1 <= (state_q == ST_XFORM) && !x_end_q;
			nstart_q <= xv_s1 && (r_s1 == 2'd2) && (c_s1 == 2'd3);
			if (state_q == ST_DONE && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && req.operation == OP_SKIN) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (slot_q[2] && !rd_v_s1 && !v_s2) begin
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: state_q <= ST_XFORM;
				ST_XFORM: begin
					if (nstart_q) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (ndone) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && req.operation == OP_SKIN) begin
			slots_q <= req.bone_slots;
			wts_q <= req.slot_weights;
			p_q[0] <= req.pos_x;
			p_q[1] <= req.pos_y;
			p_q[2] <= req.pos_z;
			n_q[0] <= req.nrm_x;
			n_q[1] <= req.nrm_y;
			n_q[2] <= req.nrm_z;
			slot_q <= '0;
			elem_q <= '0;
			sat_q <= 1'b0;
			r_q <= '0;
			c_q <= '0;
			x_end_q <= 1'b0;
			for (int e = 0; e < WORDS_PER_BONE; e++) begin
				acc_q[e] <= '0;
			end
		end

		if (state_q == ST_READ && !slot_q[2]) begin
			if (!slot_ok || elem_q == 4'(WORDS_PER_BONE - 1)) begin
				slot_q <= slot_q + 3'd1;
				elem_q <= '0;
			end else begin
				elem_q <= elem_q + 4'd1;
			end
		end
		elem_s1 <= elem_q;
		w_s1 <= cur_w;
		prod_s2 <= signed'(rdata) * signed'({1'b0, w_s1});
		elem_s2 <= elem_s1;
		if (v_s2) begin
			acc_q[elem_s2] <= acc_q[elem_s2] + 51'(prod_s2);
		end

		if (state_q == ST_BLEND) begin
			for (int e = 0; e < WORDS_PER_BONE; e++) begin
				m_q[e] <= msat[e].val;
			end
			if (mclip) begin
				sat_q <= 1'b1;
			end
		end

		if (state_q == ST_XFORM && !x_end_q) begin
			pp_s1 <= m_q[{r_q, c_q}] * p_op;
			np_s1 <= m_q[{r_q, c_q}] * n_op;
			r_s1 <= r_q;
			c_s1 <= c_q;
			c_q <= c_q + 2'd1;
			if (c_q == 2'd3) begin
				r_q <= r_q + 2'd1;
				if (r_q == 2'd2) begin
					x_end_q <= 1'b1;
				end
			end
		end
		if (xv_s1) begin
			psum_q <= newp;
			nsum_q <= newn;
			if (c_s1 == 2'd3) begin
				o_q[r_s1] <= osat.val;
				nres_q[r_s1] <= newn;
				if (osat.clip) begin
					sat_q <= 1'b1;
				end
			end
		end

		if (state_q == ST_DONE && out_free) begin
			rsp.out_x <= o_q[0];
			rsp.out_y <= o_q[1];
			rsp.out_z <= o_q[2];
			rsp.out_nx <= nres.nx;
			rsp.out_ny <= nres.ny;
			rsp.out_nz <= nres.nz;
			rsp.normal_zero <= nres.zero;
			rsp.saturated <= sat_q;
		end
	end

	assign rsp.valid = ov_q;
endmodule
`default_nettype wire
